// ===== rtl/bqc_pkg.sv =====
// shared types, constants and helpers for the cascaded biquad filter
package bqc_pkg;

    localparam int MAX_STAGES_DEF = 4;
    localparam int SAMPLE_W       = 16;
    localparam int ACC_W          = 32;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int STEP_W         = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B1H    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_B2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A1H    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_A2     = 3'd5;

    localparam logic [2:0] STAGE_COUNT_RESET = 3'd2;

    // multiply steps of one stage; the last step only accumulates and writes back
    localparam logic [STEP_W-1:0] STEP_B0    = 3'd0;
    localparam logic [STEP_W-1:0] STEP_B1H_A = 3'd1;
    localparam logic [STEP_W-1:0] STEP_B1H_B = 3'd2;
    localparam logic [STEP_W-1:0] STEP_B2    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_A1H_A = 3'd4;
    localparam logic [STEP_W-1:0] STEP_A1H_B = 3'd5;
    localparam logic [STEP_W-1:0] STEP_A2    = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST  = 3'd7;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // signed 16-bit lane of a packed coefficient word
    function automatic logic signed [SAMPLE_W-1:0] lane(
        input logic [CFG_DATA_W-1:0] packed_w,
        input logic [1:0]            idx
    );
        logic signed [SAMPLE_W-1:0] r;
        case (idx)
            2'd0:    r = packed_w[15:0];
            2'd1:    r = packed_w[31:16];
            2'd2:    r = packed_w[47:32];
            2'd3:    r = packed_w[63:48];
            default: r = packed_w[15:0];
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bqc_if.sv =====
// channel interfaces: input samples, filtered samples and register writes
interface bqc_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bqc_pkg::SAMPLE_W-1:0]    sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqc_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [bqc_pkg::SAMPLE_W-1:0]    sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

interface bqc_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [bqc_pkg::CFG_IDX_W-1:0]          index;
    logic [bqc_pkg::CFG_DATA_W-1:0]         data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/cascaded_biquad_iir_q15.sv =====
// cascaded direct-form-I biquad filter, Q15, one shared multiplier
//
// Each accepted sample runs through the active stages (1 to MAX_STAGES, set by
// the stage count register) one after the other on a single 16x16 multiplier
// followed by a saturating 32-bit accumulator. A stage issues seven multiplies
// back to back, each product registered and accumulated in the step after it,
// and the last accumulate writes the stage histories. A sample occupies the
// block until every active stage has run, and the result sits in an output
// register so the next sample can be taken while it waits. Coefficient and
// stage count registers may be written only when no sample is in flight.
module cascaded_biquad_iir_q15 #(
    parameter int MAX_STAGES = bqc_pkg::MAX_STAGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    bqc_cfg_if.sink         cfg,
    bqc_in_if.sink          feed,
    bqc_out_if.source       filtered
);

    localparam int STAGE_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam logic [2:0] MAX_COUNT = 3'(MAX_STAGES);

    // configuration registers
    logic [2:0]                          stage_count_reg;
    logic [bqc_pkg::CFG_DATA_W-1:0]      coef_b0_reg;
    logic [bqc_pkg::CFG_DATA_W-1:0]      coef_b1h_reg;
    logic [bqc_pkg::CFG_DATA_W-1:0]      coef_b2_reg;
    logic [bqc_pkg::CFG_DATA_W-1:0]      coef_a1h_reg;
    logic [bqc_pkg::CFG_DATA_W-1:0]      coef_a2_reg;

    // per-stage histories
    logic signed [bqc_pkg::SAMPLE_W-1:0] x1_reg [MAX_STAGES];
    logic signed [bqc_pkg::SAMPLE_W-1:0] x2_reg [MAX_STAGES];
    logic signed [bqc_pkg::SAMPLE_W-1:0] y1_reg [MAX_STAGES];
    logic signed [bqc_pkg::SAMPLE_W-1:0] y2_reg [MAX_STAGES];

    // sequencer and datapath
    bqc_pkg::state_t                     state_reg, state_next;
    logic [STAGE_W-1:0]                  stage_reg;
    logic [bqc_pkg::STEP_W-1:0]          step_reg;
    logic signed [bqc_pkg::SAMPLE_W-1:0] x_cur_reg;
    logic signed [bqc_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [bqc_pkg::ACC_W-1:0]    prod_reg, prod_next;
    logic                                sub_reg;
    logic                                out_valid_reg;
    logic signed [bqc_pkg::SAMPLE_W-1:0] out_data_reg;

    logic [STAGE_W-1:0]                  last_stage;
    logic                                is_last_stage;
    logic                                accept;
    logic                                stall;
    logic                                advance;
    logic                                finish;
    logic signed [bqc_pkg::SAMPLE_W-1:0] op_coef;
    logic signed [bqc_pkg::SAMPLE_W-1:0] op_data;
    logic [1:0]                          lane_idx;
    logic signed [bqc_pkg::ACC_W-1:0]    acc_base;
    logic signed [bqc_pkg::ACC_W+1:0]    acc_wide;
    logic signed [bqc_pkg::ACC_W+1:0]    prod_wide;
    logic signed [bqc_pkg::ACC_W+1:0]    sum_wide;
    logic signed [bqc_pkg::SAMPLE_W-1:0] y_new;

    // active stage range, zero counts as one and large counts clamp
    always_comb
    begin
        if (stage_count_reg == 3'd0)
        begin
            last_stage = '0;
        end
        else if (stage_count_reg > MAX_COUNT)
        begin
            last_stage = STAGE_W'(MAX_STAGES - 1);
        end
        else
        begin
            last_stage = STAGE_W'(stage_count_reg - 3'd1);
        end
    end

    assign is_last_stage = (stage_reg == last_stage);
    assign lane_idx      = 2'(stage_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        case (step_reg)
            bqc_pkg::STEP_B0:
            begin
                op_coef = bqc_pkg::lane(coef_b0_reg, lane_idx);
                op_data = x_cur_reg;
            end
            bqc_pkg::STEP_B1H_A, bqc_pkg::STEP_B1H_B:
            begin
                op_coef = bqc_pkg::lane(coef_b1h_reg, lane_idx);
                op_data = x1_reg[stage_reg];
            end
            bqc_pkg::STEP_B2:
            begin
                op_coef = bqc_pkg::lane(coef_b2_reg, lane_idx);
                op_data = x2_reg[stage_reg];
            end
            bqc_pkg::STEP_A1H_A, bqc_pkg::STEP_A1H_B:
            begin
                op_coef = bqc_pkg::lane(coef_a1h_reg, lane_idx);
                op_data = y1_reg[stage_reg];
            end
            bqc_pkg::STEP_A2:
            begin
                op_coef = bqc_pkg::lane(coef_a2_reg, lane_idx);
                op_data = y2_reg[stage_reg];
            end
            default:
            begin
                op_coef = '0;
                op_data = '0;
            end
        endcase
    end

    assign prod_next = bqc_pkg::ACC_W'(op_coef) * bqc_pkg::ACC_W'(op_data);

    // accumulate the product issued in the previous step, doubled, saturating
    always_comb
    begin
        acc_base  = (step_reg == bqc_pkg::STEP_B1H_A) ? '0 : acc_reg;
        acc_wide  = {{2{acc_base[bqc_pkg::ACC_W-1]}}, acc_base};
        prod_wide = {prod_reg[bqc_pkg::ACC_W-1], prod_reg, 1'b0};
        sum_wide  = sub_reg ? (acc_wide - prod_wide) : (acc_wide + prod_wide);
        if ((sum_wide[bqc_pkg::ACC_W+1:bqc_pkg::ACC_W-1] == 3'b000)
            || (sum_wide[bqc_pkg::ACC_W+1:bqc_pkg::ACC_W-1] == 3'b111))
        begin
            acc_next = sum_wide[bqc_pkg::ACC_W-1:0];
        end
        else if (sum_wide[bqc_pkg::ACC_W+1])
        begin
            acc_next = {1'b1, {(bqc_pkg::ACC_W-1){1'b0}}};
        end
        else
        begin
            acc_next = {1'b0, {(bqc_pkg::ACC_W-1){1'b1}}};
        end
        y_new = acc_next[bqc_pkg::ACC_W-1:bqc_pkg::ACC_W-bqc_pkg::SAMPLE_W];
    end

    // handshake and sequencing outputs
    always_comb
    begin
        cfg.ready          = 1'b1;
        feed.ready         = (state_reg == bqc_pkg::ST_IDLE);
        filtered.valid     = out_valid_reg;
        filtered.sample_out = out_data_reg;
        accept             = feed.valid && feed.ready;
        stall              = (state_reg == bqc_pkg::ST_RUN)
                             && (step_reg == bqc_pkg::STEP_LAST)
                             && is_last_stage && out_valid_reg && !filtered.ready;
        advance            = (state_reg == bqc_pkg::ST_RUN) && !stall;
        finish             = advance && (step_reg == bqc_pkg::STEP_LAST) && is_last_stage;
    end

    // next state
    always_comb
    begin
        case (state_reg)
            bqc_pkg::ST_IDLE:
            begin
                state_next = accept ? bqc_pkg::ST_RUN : bqc_pkg::ST_IDLE;
            end
            bqc_pkg::ST_RUN:
            begin
                state_next = finish ? bqc_pkg::ST_IDLE : bqc_pkg::ST_RUN;
            end
            default:
            begin
                state_next = bqc_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_count_reg <= bqc_pkg::STAGE_COUNT_RESET;
            coef_b0_reg     <= '0;
            coef_b1h_reg    <= '0;
            coef_b2_reg     <= '0;
            coef_a1h_reg    <= '0;
            coef_a2_reg     <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                bqc_pkg::REG_STAGE_COUNT: stage_count_reg <= cfg.data[2:0];
                bqc_pkg::REG_COEF_B0:     coef_b0_reg     <= cfg.data;
                bqc_pkg::REG_COEF_B1H:    coef_b1h_reg    <= cfg.data;
                bqc_pkg::REG_COEF_B2:     coef_b2_reg     <= cfg.data;
                bqc_pkg::REG_COEF_A1H:    coef_a1h_reg    <= cfg.data;
                bqc_pkg::REG_COEF_A2:     coef_a2_reg     <= cfg.data;
                default:                  ;
            endcase
        end
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bqc_pkg::ST_IDLE;
            stage_reg     <= '0;
            step_reg      <= bqc_pkg::STEP_B0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                stage_reg <= '0;
                step_reg  <= bqc_pkg::STEP_B0;
            end
            else if (advance)
            begin
                step_reg <= step_reg + 3'd1;
                if ((step_reg == bqc_pkg::STEP_LAST) && !is_last_stage)
                begin
                    stage_reg <= stage_reg + STAGE_W'(1);
                end
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (filtered.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // histories
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
        end
        else if (advance && (step_reg == bqc_pkg::STEP_LAST))
        begin
            x1_reg[stage_reg] <= x_cur_reg;
            x2_reg[stage_reg] <= x1_reg[stage_reg];
            y1_reg[stage_reg] <= y_new;
            y2_reg[stage_reg] <= y1_reg[stage_reg];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_cur_reg <= feed.sample_in;
        end
        else if (advance)
        begin
            prod_reg <= prod_next;
            sub_reg  <= (step_reg == bqc_pkg::STEP_A1H_A)
                        || (step_reg == bqc_pkg::STEP_A1H_B)
                        || (step_reg == bqc_pkg::STEP_A2);
            if (step_reg != bqc_pkg::STEP_B0)
            begin
                acc_reg <= acc_next;
            end
            if (step_reg == bqc_pkg::STEP_LAST)
            begin
                // stage output becomes the next stage input
                x_cur_reg <= y_new;
            end
        end
        if (finish)
        begin
            out_data_reg <= y_new;
        end
    end

    a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == bqc_pkg::ST_RUN) && (stage_reg == '0)
                   && (step_reg == bqc_pkg::STEP_B0))
        else $error("accepted sample did not start at the first stage");

    a_stage_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bqc_pkg::ST_RUN) |-> (stage_reg <= last_stage))
        else $error("stage index beyond the active stages");

    a_result_after_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past((state_reg == bqc_pkg::ST_RUN)
                                       && (step_reg == bqc_pkg::STEP_LAST)
                                       && is_last_stage))
        else $error("result appeared without a finished last stage");

    a_stall_holds_run: assert property (@(posedge clk) disable iff (!rst_n)
        stall |=> (state_reg == bqc_pkg::ST_RUN) && (step_reg == bqc_pkg::STEP_LAST)
                  && $stable(stage_reg))
        else $error("sequencer moved on while the output register was full");

endmodule
